// ===== hdl/bdmh_pkg.sv =====
// Shared types, codes and defaults for the bottom-d min-hash row sketch.
package bdmh_pkg;

    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_DEPTH_DEF = 16;
    localparam int HASH_BITS_DEF = 64;

    localparam int FUNC_W     = 2;
    localparam int ROW_IN_W   = 6;
    localparam int VAL_W      = 64;
    localparam int STATUS_W   = 2;
    localparam int OUT_FILL_W = 5;

    localparam int DEPTH_CFG_W = 5;
    localparam int ROWS_CFG_W  = 7;
    localparam int CFG_DATA_W  = 7;
    localparam logic [DEPTH_CFG_W-1:0] DEPTH_RST = 5'd16;
    localparam logic [ROWS_CFG_W-1:0]  ROWS_RST  = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_READ   = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_REBUILD = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        CFG_DEPTH = 1'b0,
        CFG_ROWS  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [ROW_IN_W-1:0] row;
        logic [VAL_W-1:0]    hash_value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [VAL_W-1:0]      row_minimum;
        logic [OUT_FILL_W-1:0] row_fill;
        logic                  rebuild_needed;
    } t_out_item;

    // value memory read address select
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_K1   = 2'd1,
        RD_K2   = 2'd2
    } t_rd_sel;

    // value memory write data select
    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_W     = 2'd1,
        WR_CARRY = 2'd2,
        WR_RDATA = 2'd3
    } t_wr_sel;

    typedef struct packed {
        logic    accept;
        logic    setup;
        logic    k_inc;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        logic    carry_ld;
        logic    cnt_ins;
        logic    cnt_del;
        logic    flag_set;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  oor;
        logic  flag;
        logic  lt;
        logic  eq;
        logic  room;
        logic  k_lt_n;
        logic  k1_lt_cnt;
        logic  cnt_zero;
        logic  cnt_one;
        logic  out_busy;
    } t_dp_stat;

endpackage

// ===== hdl/bdmh_ctrl.sv =====
// Sequencer: walks one operation through count read, row scan, shift and result.
module bdmh_ctrl import bdmh_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_COUNT = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SHUP  = 7'b0001000,
        S_SHDN  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.rd_sel  = RD_ZERO;
        o_cmd.wr_sel  = WR_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_COUNT;
                end
            end
            S_COUNT: begin
                o_cmd.setup = 1'b1;
                if (i_stat.func == FN_CLEAR || i_stat.oor || i_stat.flag ||
                    i_stat.func == FN_READ) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.lt) begin
                    // advance past smaller entries
                    o_cmd.k_inc  = 1'b1;
                    o_cmd.rd_sel = RD_K1;
                end else if (i_stat.func == FN_INSERT) begin
                    if (i_stat.eq || !i_stat.room) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.cnt_ins = 1'b1;
                        if (i_stat.k_lt_n) begin
                            o_cmd.wr_sel   = WR_W;
                            o_cmd.carry_ld = 1'b1;
                            o_cmd.k_inc    = 1'b1;
                            o_cmd.rd_sel   = RD_K1;
                            n_state        = S_SHUP;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                end else begin
                    if (i_stat.eq) begin
                        o_cmd.cnt_del  = 1'b1;
                        o_cmd.flag_set = i_stat.cnt_one;
                        o_cmd.rd_sel   = RD_K1;
                        n_state        = S_SHDN;
                    end else begin
                        o_cmd.flag_set = i_stat.cnt_zero;
                        n_state        = S_FIN;
                    end
                end
            end
            S_SHUP: begin
                if (i_stat.k_lt_n) begin
                    o_cmd.wr_sel   = WR_CARRY;
                    o_cmd.carry_ld = 1'b1;
                    o_cmd.k_inc    = 1'b1;
                    o_cmd.rd_sel   = RD_K1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SHDN: begin
                if (i_stat.k1_lt_cnt) begin
                    o_cmd.wr_sel = WR_RDATA;
                    o_cmd.k_inc  = 1'b1;
                    o_cmd.rd_sel = RD_K2;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/bdmh_dpath.sv =====
// Datapath: config registers, row counts, value memory, compare and output register.
module bdmh_dpath import bdmh_pkg::*; #(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int HASH_BITS = HASH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_in_item,
    input  logic                  i_cfg_wr,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_item,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SLOT_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int MEM_DEPTH = MAX_ROWS << SLOT_W;
    localparam int ADDR_W    = ROW_W + SLOT_W;

    // configuration
    logic [DEPTH_CFG_W-1:0] r_depth_cfg;
    logic [ROWS_CFG_W-1:0]  r_rows_cfg;
    logic [CNT_W-1:0]       eff_depth;
    logic [ROWS_CFG_W-1:0]  rows_lim;

    // operation in flight
    t_func                r_func;
    logic [ROW_W-1:0]     r_row;
    logic                 r_oor;
    logic [HASH_BITS-1:0] r_w;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_k;
    logic [CNT_W-1:0]     r_fill;
    logic [HASH_BITS-1:0] r_carry;
    t_status              r_status;
    logic                 r_flag;

    // row counts
    logic [CNT_W-1:0]    r_cnt_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_cnt_vld;
    logic [CNT_W-1:0]    r_cnt_rd;
    logic                r_cnt_rv;
    logic [CNT_W-1:0]    cur_cnt;
    logic                cnt_we;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [CNT_W-1:0]    cnt_m1;

    // value memory
    logic [HASH_BITS-1:0] r_mem [MEM_DEPTH];
    logic [HASH_BITS-1:0] r_rdata;
    logic [ADDR_W-1:0]    raddr;
    logic [ADDR_W-1:0]    waddr;
    logic [SLOT_W-1:0]    rslot;
    logic                 we;
    logic [HASH_BITS-1:0] wdata;

    logic [ROW_W+ROW_IN_W-1:0] row_ext;
    logic [ROW_W-1:0]          in_row;
    logic                      in_oor;
    logic                      clear_now;
    logic [CNT_W:0]            k_p1;
    logic [CNT_W:0]            k_p2;
    logic [CNT_W:0]            cnt_p1;
    logic [CNT_W-1:0]          n_next;
    t_status                   setup_status;
    logic [CNT_W-1:0]          setup_fill;
    logic [VAL_W+HASH_BITS-1:0]  min_ext;
    logic [OUT_FILL_W+CNT_W-1:0] fill_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_cfg <= DEPTH_RST;
            r_rows_cfg  <= ROWS_RST;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_DEPTH: r_depth_cfg <= i_cfg_data[DEPTH_CFG_W-1:0];
                CFG_ROWS:  r_rows_cfg  <= i_cfg_data[ROWS_CFG_W-1:0];
                default:   r_rows_cfg  <= r_rows_cfg;
            endcase
        end
    end

    // saturate the depth into 1..MAX_DEPTH
    always_comb begin
        if (r_depth_cfg == '0) begin
            eff_depth = CNT_W'(1);
        end else if (32'(r_depth_cfg) > MAX_DEPTH) begin
            eff_depth = CNT_W'(MAX_DEPTH);
        end else begin
            eff_depth = CNT_W'(r_depth_cfg);
        end
    end

    assign rows_lim = (r_rows_cfg == '0) ? ROWS_CFG_W'(1) : r_rows_cfg;
    assign row_ext  = {{ROW_W{1'b0}}, i_in_item.row};
    assign in_row   = row_ext[ROW_W-1:0];
    assign in_oor   = ({1'b0, i_in_item.row} >= rows_lim) ||
                      (32'(i_in_item.row) >= MAX_ROWS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= t_func'(i_in_item.func);
            r_row  <= in_row;
            r_oor  <= in_oor;
            r_w    <= i_in_item.hash_value[HASH_BITS-1:0];
        end
    end

    // row count store: valid bits stand in for the cleared state
    assign cur_cnt   = r_cnt_rv ? r_cnt_rd : '0;
    assign clear_now = i_cmd.setup && (r_func == FN_CLEAR);
    assign cnt_m1    = r_cnt - CNT_W'(1);
    assign cnt_we    = i_cmd.cnt_ins || i_cmd.cnt_del;
    assign cnt_wdata = i_cmd.cnt_ins ? r_n : cnt_m1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cnt_rd <= r_cnt_mem[in_row];
            r_cnt_rv <= r_cnt_vld[in_row];
        end
        if (cnt_we) begin
            r_cnt_mem[r_row] <= cnt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (clear_now) begin
            r_cnt_vld <= '0;
        end else if (cnt_we) begin
            r_cnt_vld[r_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (clear_now) begin
            r_flag <= 1'b0;
        end else if (i_cmd.flag_set) begin
            r_flag <= 1'b1;
        end
    end

    // size after an accepted insert: min(count + 1, depth)
    assign cnt_p1 = {1'b0, cur_cnt} + (CNT_W+1)'(1);
    assign n_next = (cnt_p1 < {1'b0, eff_depth}) ? cnt_p1[CNT_W-1:0] : eff_depth;

    always_comb begin
        if (r_func == FN_CLEAR) begin
            setup_status = ST_OK;
            setup_fill   = '0;
        end else if (r_oor) begin
            setup_status = ST_RANGE;
            setup_fill   = '0;
        end else if (r_flag) begin
            setup_status = ST_REBUILD;
            setup_fill   = cur_cnt;
        end else if (r_func == FN_READ && cur_cnt == '0) begin
            setup_status = ST_EMPTY;
            setup_fill   = '0;
        end else begin
            setup_status = ST_OK;
            setup_fill   = cur_cnt;
        end
    end

    assign k_p1 = {1'b0, r_k} + (CNT_W+1)'(1);
    assign k_p2 = {1'b0, r_k} + (CNT_W+1)'(2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_cnt    <= cur_cnt;
            r_n      <= n_next;
            r_k      <= '0;
            r_status <= setup_status;
            r_fill   <= setup_fill;
        end else begin
            if (i_cmd.k_inc) begin
                r_k <= k_p1[CNT_W-1:0];
            end
            if (i_cmd.cnt_ins) begin
                r_fill <= r_n;
            end else if (i_cmd.cnt_del) begin
                r_fill <= cnt_m1;
            end
        end
        if (i_cmd.carry_ld) begin
            r_carry <= r_rdata;
        end
    end

    // value memory: one row occupies 2**SLOT_W words
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_K1:   rslot = k_p1[SLOT_W-1:0];
            RD_K2:   rslot = k_p2[SLOT_W-1:0];
            default: rslot = '0;
        endcase
    end

    always_comb begin
        we = 1'b1;
        unique case (i_cmd.wr_sel)
            WR_W:     wdata = r_w;
            WR_CARRY: wdata = r_carry;
            WR_RDATA: wdata = r_rdata;
            default: begin
                wdata = r_w;
                we    = 1'b0;
            end
        endcase
    end

    assign raddr = {r_row, rslot};
    assign waddr = {r_row, r_k[SLOT_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    assign o_stat.func      = r_func;
    assign o_stat.oor       = r_oor;
    assign o_stat.flag      = r_flag;
    assign o_stat.lt        = (r_k < r_cnt) && (r_rdata < r_w);
    assign o_stat.eq        = (r_k < r_cnt) && (r_rdata == r_w);
    assign o_stat.room      = (r_cnt < eff_depth) || (r_k < r_cnt);
    assign o_stat.k_lt_n    = (r_k < r_n);
    assign o_stat.k1_lt_cnt = (k_p1 < {1'b0, r_cnt});
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.cnt_one   = (r_cnt == CNT_W'(1));
    assign o_stat.out_busy  = o_out_valid && i_out_stall;

    // result register
    assign min_ext  = {{VAL_W{1'b0}}, r_rdata};
    assign fill_ext = {{OUT_FILL_W{1'b0}}, r_fill};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_item.status         <= r_status;
            o_out_item.row_minimum    <= (r_fill == '0) ? '0 : min_ext[VAL_W-1:0];
            o_out_item.row_fill       <= fill_ext[OUT_FILL_W-1:0];
            o_out_item.rebuild_needed <= r_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

endmodule

// ===== hdl/bottom_d_min_hash_rows_top.sv =====
// Top level of the bottom-d min-hash row sketch.
//
// Keeps up to MAX_ROWS rows, each an ascending list of the smallest distinct
// hash values seen, at most depth_in_use of them. One transfer on the input
// channel carries one operation (insert, delete, read row minimum, clear all)
// and yields exactly one result transfer with the status, the row's minimum and
// fill after the operation, and the sticky rebuild flag. Operations run one at
// a time: a sorted insert or delete walks the row through the value memory
// (one read and one write port) one entry per cycle, first scanning for the
// position and then shifting the tail. The input channel stalls while an
// operation is in progress; a finished result waits in its own register, so
// the next input transfer is taken while the previous result is still stalled
// downstream. Clear empties all rows by resetting per-row valid bits, so no
// clearing pass runs after reset. Configuration writes are always ready and
// are to be issued only while the block is idle. Values are kept as HASH_BITS
// bits of the input.
module bottom_d_min_hash_rows_top import bdmh_pkg::*; #(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int HASH_BITS = HASH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // operation input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    bdmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    bdmh_dpath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_DEPTH (MAX_DEPTH),
        .HASH_BITS (HASH_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

// ===== hdl/bdmh_checker.sv =====
// Port-level checks for the min-hash row sketch, bound to the top level.
module bdmh_checker import bdmh_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // one operation at a time: an input transfer stalls the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an operation was in progress");

    // clear with a free output register passes the count, finish and done states, then shows an empty OK result
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.func == FN_CLEAR && !o_out_valid)
        |-> ##4 (o_out_valid && o_out_item.status == ST_OK &&
                 o_out_item.row_fill == '0 && o_out_item.row_minimum == '0 &&
                 !o_out_item.rebuild_needed))
        else $error("clear result wrong or late");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // no result leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind bottom_d_min_hash_rows_top bdmh_checker u_bdmh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
